@@ rtl/tdts_pkg.sv @@
// shared types, kind codes, keyword table and queue sizing for the token scanner
package tdts_pkg;

	localparam int KIND_W = 5;
	localparam int LINE_W = 16;
	localparam int LEN_W  = 8;
	localparam int TEXT_W = 64;

	// default number of token bytes kept in the text field
	localparam int TEXT_CHARS_DEF = 8;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_END       = 5'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd1;
	localparam logic [KIND_W-1:0] KIND_PUNCT     = 5'd2;
	localparam logic [KIND_W-1:0] KIND_INT       = 5'd3;
	localparam logic [KIND_W-1:0] KIND_KW_FIRST  = 5'd4;
	localparam logic [KIND_W-1:0] KIND_KW_LAST   = 5'd15;
	localparam logic [KIND_W-1:0] KIND_BAD_CHAR  = 5'd16;
	localparam logic [KIND_W-1:0] KIND_BAD_TOKEN = 5'd17;

	// keywords, first byte in the low bits
	localparam int NUM_KW = 12;
	localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
		64'h0000_006e_6967_6562, // begin
		64'h0000_0000_0064_6e65, // end
		64'h0000_0000_7265_7469, // iter
		64'h0000_0000_6469_6f76, // void
		64'h0000_0000_0072_6176, // var
		64'h0000_6e72_7574_6572, // return
		64'h0000_0000_6461_6572, // read
		64'h0000_0074_6e69_7270, // print
		64'h006d_6172_676f_7270, // program
		64'h0000_0000_646e_6f63, // cond
		64'h0000_0000_6e65_6874, // then
		64'h0000_0000_0074_656c  // let
	};
	localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
		8'd5, 8'd3, 8'd4, 8'd4, 8'd3, 8'd6, 8'd4, 8'd5, 8'd7, 8'd4, 8'd4, 8'd3
	};

	// token queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LINE_W-1:0] line;
		logic [LEN_W-1:0]  length;
		logic [TEXT_W-1:0] text;
		logic              truncated;
		logic              last;
	} rec_t;

	// up to two token records per byte
	typedef struct packed {
		logic valid0;
		logic valid1;
		rec_t rec0;
		rec_t rec1;
	} q_wr_t;

	typedef struct packed {
		logic room2;
		logic not_empty;
	} q_stat_t;

endpackage

@@ rtl/tdts_front.sv @@
// front end: byte classification, scan state machine and token assembly
module tdts_front #(
	parameter int TEXT_CHARS = tdts_pkg::TEXT_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        ch,
	output tdts_pkg::q_wr_t   wr
);

	localparam int LEN_W  = tdts_pkg::LEN_W;
	localparam int LINE_W = tdts_pkg::LINE_W;
	localparam int TW     = tdts_pkg::TEXT_W;
	localparam int BUF_W  = TEXT_CHARS * 8;

	typedef enum logic [2:0] {
		SC_START, SC_IDENT, SC_PUNCT, SC_INT, SC_COMMENT
	} scan_state_t;

	typedef enum logic [2:0] {
		CL_SPACE, CL_LOWER, CL_UPPER, CL_DIGIT, CL_PUNCT, CL_HASH, CL_NUL, CL_BAD
	} class_t;

	typedef enum logic [3:0] {
		ACT_START, ACT_IDENT_RUN, ACT_PUNCT_RUN, ACT_INT_RUN, ACT_COMMENT,
		ACT_EOF, ACT_END_IDENT, ACT_END_PUNCT, ACT_END_INT, ACT_BAD_CHAR, ACT_BAD_TOKEN
	} action_t;

	function automatic class_t classify(input logic [7:0] c);
		class_t r;
		r = CL_BAD;
		if (c == 8'd0) r = CL_NUL;
		else if (c == "#") r = CL_HASH;
		else if (c == " " || (c >= 8'd9 && c <= 8'd13)) r = CL_SPACE;
		else if (c >= "a" && c <= "z") r = CL_LOWER;
		else if (c >= "A" && c <= "Z") r = CL_UPPER;
		else if (c >= "0" && c <= "9") r = CL_DIGIT;
		else begin
			case (c)
				"=", "<", ">", ":", "+", "-", "*", "/", "%",
				".", "(", ")", ",", "{", "}", ";", "[", "]": r = CL_PUNCT;
				default: r = CL_BAD;
			endcase
		end
		return r;
	endfunction

	// transition table of the scanner
	function automatic action_t step(input scan_state_t s, input class_t c);
		action_t a;
		a = ACT_START;
		case (s)
			SC_START: begin
				case (c)
					CL_SPACE: a = ACT_START;
					CL_LOWER: a = ACT_IDENT_RUN;
					CL_UPPER: a = ACT_BAD_TOKEN;
					CL_DIGIT: a = ACT_INT_RUN;
					CL_PUNCT: a = ACT_PUNCT_RUN;
					CL_HASH:  a = ACT_COMMENT;
					CL_NUL:   a = ACT_EOF;
					default:  a = ACT_BAD_CHAR;
				endcase
			end
			SC_IDENT: begin
				case (c)
					CL_LOWER, CL_UPPER, CL_DIGIT: a = ACT_IDENT_RUN;
					CL_BAD:  a = ACT_BAD_CHAR;
					default: a = ACT_END_IDENT;
				endcase
			end
			SC_PUNCT: begin
				case (c)
					CL_BAD:  a = ACT_BAD_CHAR;
					default: a = ACT_END_PUNCT;
				endcase
			end
			SC_INT: begin
				case (c)
					CL_DIGIT: a = ACT_INT_RUN;
					CL_BAD:   a = ACT_BAD_CHAR;
					default:  a = ACT_END_INT;
				endcase
			end
			SC_COMMENT: begin
				case (c)
					CL_HASH: a = ACT_START;
					CL_NUL:  a = ACT_EOF;
					default: a = ACT_COMMENT;
				endcase
			end
			default: a = ACT_START;
		endcase
		return a;
	endfunction

	scan_state_t       state_q;
	logic [LINE_W-1:0] line_q;
	logic [LEN_W-1:0]  len_q;
	logic [BUF_W-1:0]  text_q;

	class_t            cls;
	action_t           act0;
	action_t           act1;
	logic              split;
	logic              fin;
	logic [LEN_W-1:0]  base_len;
	logic [BUF_W-1:0]  base_text;
	logic [LEN_W-1:0]  app_len;
	logic [BUF_W-1:0]  app_text;
	tdts_pkg::rec_t    r0;
	tdts_pkg::rec_t    r1;

	always_comb begin
		cls   = classify(ch);
		act0  = step(state_q, cls);
		split = (act0 == ACT_END_IDENT) || (act0 == ACT_END_PUNCT) || (act0 == ACT_END_INT);
		// a finished token sends the same byte round again from the start
		act1  = split ? step(SC_START, cls) : act0;
		fin   = (act1 == ACT_EOF) || (act1 == ACT_BAD_CHAR) || (act1 == ACT_BAD_TOKEN);

		base_len  = split ? '0 : len_q;
		base_text = split ? '0 : text_q;
		app_len   = (base_len == '1) ? base_len : base_len + LEN_W'(1);
		app_text  = base_text;
		for (int i = 0; i < TEXT_CHARS; i++) begin
			if (base_len == LEN_W'(i)) app_text[i*8 +: 8] = ch;
		end

		// token closed by this byte
		case (act0)
			ACT_END_IDENT: r0.kind = tdts_pkg::KIND_IDENT;
			ACT_END_PUNCT: r0.kind = tdts_pkg::KIND_PUNCT;
			default:       r0.kind = tdts_pkg::KIND_INT;
		endcase
		r0.line      = line_q;
		r0.length    = len_q;
		r0.text      = TW'(text_q);
		r0.truncated = len_q > LEN_W'(TEXT_CHARS);
		r0.last      = !fin;

		// end or error word
		case (act1)
			ACT_BAD_CHAR:  r1.kind = tdts_pkg::KIND_BAD_CHAR;
			ACT_BAD_TOKEN: r1.kind = tdts_pkg::KIND_BAD_TOKEN;
			default:       r1.kind = tdts_pkg::KIND_END;
		endcase
		r1.line = line_q;
		if (act1 == ACT_EOF) begin
			r1.length    = '0;
			r1.text      = '0;
			r1.truncated = 1'b0;
		end else begin
			r1.length    = app_len;
			r1.text      = TW'(app_text);
			r1.truncated = app_len > LEN_W'(TEXT_CHARS);
		end
		r1.last = 1'b1;

		wr.valid0 = accept && (split || fin);
		wr.valid1 = accept && split && fin;
		wr.rec0   = split ? r0 : r1;
		wr.rec1   = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_START;
			line_q  <= LINE_W'(1);
			len_q   <= '0;
			text_q  <= '0;
		end else if (accept) begin
			if (fin) begin
				state_q <= SC_START;
				line_q  <= LINE_W'(1);
				len_q   <= '0;
				text_q  <= '0;
			end else begin
				case (act1)
					ACT_IDENT_RUN: state_q <= SC_IDENT;
					ACT_PUNCT_RUN: state_q <= SC_PUNCT;
					ACT_INT_RUN:   state_q <= SC_INT;
					ACT_COMMENT:   state_q <= SC_COMMENT;
					default:       state_q <= SC_START;
				endcase
				if (act1 == ACT_IDENT_RUN || act1 == ACT_PUNCT_RUN || act1 == ACT_INT_RUN) begin
					len_q  <= app_len;
					text_q <= app_text;
				end else begin
					len_q  <= base_len;
					text_q <= base_text;
				end
				if (ch == 8'h0A && line_q != '1) line_q <= line_q + LINE_W'(1);
			end
		end
	end

endmodule

@@ rtl/tdts_queue.sv @@
// small token queue, two writes and one read a cycle
module tdts_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tdts_pkg::q_wr_t    wr,
	input  logic               pop,
	output tdts_pkg::q_stat_t  stat,
	output tdts_pkg::rec_t     head
);

	localparam int DEPTH = tdts_pkg::QUEUE_DEPTH;
	localparam int PTR_W = tdts_pkg::Q_PTR_W;
	localparam int CNT_W = tdts_pkg::Q_CNT_W;

	tdts_pkg::rec_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  wp_inc;

	assign wp_inc = wp_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (wr.valid0) mem_q[wp_q]   <= wr.rec0;
		if (wr.valid1) mem_q[wp_inc] <= wr.rec1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(wr.valid0) + PTR_W'(wr.valid1);
			if (pop) rp_q <= rp_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(wr.valid0) + CNT_W'(wr.valid1) - CNT_W'(pop);
		end
	end

	assign stat.room2     = cnt_q <= CNT_W'(DEPTH - 2);
	assign stat.not_empty = cnt_q != '0;
	assign head           = mem_q[rp_q];

endmodule

@@ rtl/tdts_back.sv @@
// back end: keyword lookup and output register
module tdts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tdts_pkg::q_stat_t  stat,
	input  tdts_pkg::rec_t     head,
	output logic               pop,
	input  logic               token_stall,
	output logic               token_valid,
	output tdts_pkg::rec_t     tok
);

	localparam int KIND_W = tdts_pkg::KIND_W;

	logic            valid_q;
	tdts_pkg::rec_t  tok_q;
	tdts_pkg::rec_t  resolved;

	// identifiers that spell a keyword take the keyword's kind
	always_comb begin
		resolved = head;
		if (head.kind == tdts_pkg::KIND_IDENT) begin
			for (int k = 0; k < tdts_pkg::NUM_KW; k++) begin
				if (head.length == tdts_pkg::KW_LEN[k] && head.text == tdts_pkg::KW_TEXT[k])
					resolved.kind = tdts_pkg::KIND_KW_FIRST + KIND_W'(k);
			end
		end
	end

	assign pop = stat.not_empty && (!valid_q || !token_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) tok_q <= resolved;
	end

	assign token_valid = valid_q;
	assign tok         = tok_q;

endmodule

@@ rtl/table_driven_token_scanner_core.sv @@
// top level of the table driven token scanner
//
//  channel | handshake                 | word
//  --------+---------------------------+-----------------------------------------------
//  byte    | byte_valid / byte_stall   | ch
//  token   | token_valid / token_stall | kind, line, length, text, truncated, last
//
// one byte is taken every cycle while the token queue has room for two words;
// a byte that closes a token and also ends the text puts two words in the queue
// the back end hands out one word a cycle while token_stall is low, so a stream of
// two-word bytes runs at the token side's pace; each word is queued, then registered
// arst_n resets the scan state, the line count to 1, the queue and the output valid
// token_stall holds the output register; the queue lets the front run on meanwhile
module table_driven_token_scanner_core #(
	parameter int TEXT_CHARS = tdts_pkg::TEXT_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// text bytes in
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  ch,
	// token words out
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  kind,
	output logic [15:0] line,
	output logic [7:0]  length,
	output logic [63:0] text,
	output logic        truncated,
	output logic        last
);

	logic               accept;
	tdts_pkg::q_wr_t    wr;
	tdts_pkg::q_stat_t  stat;
	tdts_pkg::rec_t     head;
	logic               pop;
	tdts_pkg::rec_t     tok;

	// front only runs when both words of a byte fit in the queue
	assign byte_stall = !stat.room2;
	assign accept     = byte_valid && !byte_stall;

	// classify the byte and step the scanner, closed tokens go into the queue
	tdts_front #(
		.TEXT_CHARS (TEXT_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (ch),
		.wr     (wr)
	);

	// decouples the scanner from the token side
	tdts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.stat   (stat),
		.head   (head)
	);

	// keyword lookup and registered output
	tdts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.head        (head),
		.pop         (pop),
		.token_stall (token_stall),
		.token_valid (token_valid),
		.tok         (tok)
	);

	assign kind      = tok.kind;
	assign line      = tok.line;
	assign length    = tok.length;
	assign text      = tok.text;
	assign truncated = tok.truncated;
	assign last      = tok.last;

	// end words never carry text
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && kind == tdts_pkg::KIND_END) |-> (length == 8'd0 && text == 64'd0 && !truncated))
		else $error("end word carries token text");

	// truncation flag follows the length
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (truncated == (length > 8'(TEXT_CHARS))))
		else $error("truncated flag disagrees with length");

	// end and error words close the byte
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && (kind == tdts_pkg::KIND_END || kind == tdts_pkg::KIND_BAD_CHAR
			|| kind == tdts_pkg::KIND_BAD_TOKEN)) |-> last)
		else $error("end or error word without last");

	// keywords are short, untruncated tokens
	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && kind >= tdts_pkg::KIND_KW_FIRST && kind <= tdts_pkg::KIND_KW_LAST)
			|-> (length != 8'd0 && !truncated))
		else $error("keyword word with bad length");

endmodule
